>>> design/wmrc_pkg.sv
`default_nettype none

package wmrc_pkg;

   // Sample and counter sizing
   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 16;

   // Field widths
   localparam int SAMPLE_W  = 16;
   localparam int CFG_LEN_W = 16;
   localparam int OUT_W     = 24;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;

   // Datapath widths
   localparam int SUM_W     = 32;
   localparam int FRAC_BITS = 16;
   localparam int NUM_W     = SUM_W + FRAC_BITS + 1;
   localparam int RES_W     = OUT_W + 1;
   localparam int STEP_W    = $clog2(NUM_W);
   localparam int LEN_W     = (COUNT_BITS > CFG_LEN_W) ? COUNT_BITS : CFG_LEN_W;

   localparam logic [COUNT_BITS-1:0] CNT_MAX     = '1;
   localparam logic [SUM_W-1:0]      SAMPLE_MASK = (SUM_W'(1) << SAMPLE_BITS) - SUM_W'(1);

   // Fixed-point constants (Q8.16)
   localparam logic signed [RES_W-1:0] Q_ONE   = RES_W'(65536);
   localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'(8388607);
   localparam logic [NUM_W-1:0]        Q_CLAMP = NUM_W'(8454144);

   // Reset value of the window-length control register
   localparam logic [CFG_LEN_W-1:0] WINDOW_RESET = CFG_LEN_W'(256);

   // Window queue
   localparam int FIFO_DEPTH = 2;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_SAMPLES = 1'b0,
      CSR_CAP_ENABLE     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [SUM_W-1:0] cur;
      logic [SUM_W-1:0] prev;
   } win_pair_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

`default_nettype wire

>>> design/wmrc_req_if.sv
`default_nettype none

interface wmrc_req_if
   import wmrc_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> design/wmrc_rsp_if.sv
`default_nettype none

interface wmrc_rsp_if
   import wmrc_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] relative_change;
   logic                    saturated;

   modport source (output valid, output relative_change, output saturated, input ready);
   modport sink   (input valid, input relative_change, input saturated, output ready);
endinterface

`default_nettype wire

>>> design/wmrc_fifo.sv
`default_nettype none

module wmrc_fifo
   import wmrc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire win_pair_type  push_data,
   input  wire logic          pop,
   output win_pair_type       pop_data,
   output fifo_stat_type      stat
);

   win_pair_type      mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   // Qualify requests against occupancy
   always_comb begin
      do_push   = push && (cnt_ff != FCNT_W'(FIFO_DEPTH));
      do_pop    = pop && (cnt_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store window pairs
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = mem_ff[rd_ptr_ff];
   assign stat.empty = (cnt_ff == '0);
   assign stat.full  = (cnt_ff == FCNT_W'(FIFO_DEPTH));

endmodule

`default_nettype wire

>>> design/wmrc_front.sv
`default_nettype none

module wmrc_front
   import wmrc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [CFG_LEN_W-1:0] window_samples,
   input  wire fifo_stat_type        stat,
   wmrc_req_if.sink                  req_if,
   output logic                      push,
   output win_pair_type              push_data
);

   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SUM_W-1:0]      prev_ff, prev_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  first_ff, first_in;
   logic [SUM_W:0]        sum_add;
   logic [SUM_W-1:0]      sum_nx;
   logic [COUNT_BITS-1:0] count_nx;
   logic [LEN_W-1:0]      eff_len;
   logic                  accept;
   logic                  close;

   assign req_if.ready = !stat.full;
   assign accept       = req_if.valid && req_if.ready;

   // Accumulate the sample and decide whether the window closes
   always_comb begin
      sum_add  = {1'b0, sum_ff} + {1'b0, SUM_W'(req_if.sample) & SAMPLE_MASK};
      sum_nx   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      count_nx = (count_ff == CNT_MAX) ? count_ff : count_ff + 1'b1;

      eff_len = LEN_W'(window_samples);
      if (window_samples == '0) begin
         eff_len = LEN_W'(1);
      end else if (eff_len > LEN_W'(CNT_MAX)) begin
         eff_len = LEN_W'(CNT_MAX);
      end
      close = (LEN_W'(count_nx) >= eff_len);

      sum_in   = sum_ff;
      count_in = count_ff;
      prev_in  = prev_ff;
      first_in = first_ff;
      if (accept) begin
         if (close) begin
            sum_in   = '0;
            count_in = '0;
            prev_in  = sum_nx;
            first_in = 1'b0;
         end else begin
            sum_in   = sum_nx;
            count_in = count_nx;
         end
      end

      push           = accept && close && !first_ff;
      push_data.cur  = sum_nx;
      push_data.prev = prev_ff;
   end

   // Hold window state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         prev_ff  <= '0;
         first_ff <= 1'b1;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         prev_ff  <= prev_in;
         first_ff <= first_in;
      end
   end

endmodule

`default_nettype wire

>>> design/wmrc_back.sv
`default_nettype none

module wmrc_back
   import wmrc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cap_enable,
   input  wire fifo_stat_type stat,
   input  wire win_pair_type  pop_data,
   output logic               pop,
   wmrc_rsp_if.source         rsp_if
);

   back_state_type          state_ff, state_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [SUM_W-1:0]        rem_ff, rem_in;
   logic [SUM_W-1:0]        div_ff, div_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rc_ff, rc_in;
   logic                    sat_ff, sat_in;

   logic [SUM_W:0]          rem_sh;
   logic                    ge;
   logic [NUM_W-1:0]        q_clip;
   logic signed [RES_W-1:0] v;
   logic signed [RES_W-1:0] v_out;
   logic                    v_sat;
   logic                    out_free;

   // Result from the quotient or from the zero-divisor rules
   always_comb begin
      q_clip = (num_ff > Q_CLAMP) ? Q_CLAMP : num_ff;
      v      = $signed({1'b0, q_clip[OUT_W-1:0]}) - Q_ONE;
      if (cap_enable && (v > Q_ONE)) begin
         v = Q_ONE;
      end
      v_out = v;
      v_sat = 1'b0;
      if (div_ff == '0) begin
         v_sat = 1'b1;
         if (num_ff == '0) begin
            v_out = '0;
         end else begin
            v_out = cap_enable ? Q_ONE : OUT_MAX;
         end
      end else if (v > OUT_MAX) begin
         v_out = OUT_MAX;
         v_sat = 1'b1;
      end
   end

   // One restoring division step per cycle
   always_comb begin
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      ge     = (rem_sh >= {1'b0, div_ff});
   end

   // Sequence pop, divide and output load
   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rc_in        = rc_ff;
      sat_in       = sat_ff;
      pop          = 1'b0;
      out_free     = !rsp_valid_ff || rsp_if.ready;
      unique case (state_ff)
         BK_IDLE: begin
            if (!stat.empty) begin
               pop     = 1'b1;
               num_in  = {1'b0, pop_data.cur, FRAC_BITS'(0)}
                         + NUM_W'(pop_data.prev >> 1);
               div_in  = pop_data.prev;
               rem_in  = '0;
               step_in = STEP_W'(NUM_W - 1);
               state_in = (pop_data.prev == '0) ? BK_DONE : BK_DIV;
            end
         end
         BK_DIV: begin
            rem_in  = ge ? SUM_W'(rem_sh - {1'b0, div_ff}) : rem_sh[SUM_W-1:0];
            num_in  = {num_ff[NUM_W-2:0], ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rc_in        = v_out[OUT_W-1:0];
               sat_in       = v_sat;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Hold state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
      rc_ff   <= rc_in;
      sat_ff  <= sat_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.relative_change = rc_ff;
   assign rsp_if.saturated       = sat_ff;

endmodule

`default_nettype wire

>>> design/window_mean_relative_change_top.sv
// Channel   Dir  Transfer         Payload
// req_if    in   valid & ready    sample[15:0] unsigned
// rsp_if    out  valid & ready    relative_change[23:0] signed Q8.16, saturated
// csr_*     in   csr_we           csr_index[0], csr_wdata[15:0]
//
// Samples are taken one per cycle while the window queue has room.
// Each closing window (except the first) passes through the back end as a pop,
// 49 divider steps and the output load; no divider steps when the previous sum is zero.
// The output load waits for as long as the held result stalls on rsp_if.ready.
// Windows closing faster than the back end stall req_if once the two-entry queue fills.
// Reset is synchronous and active high; the first window after it only primes the sum.
`default_nettype none

module window_mean_relative_change_top
   import wmrc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   wmrc_req_if.sink                  req_if,
   wmrc_rsp_if.source                rsp_if,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   logic [CFG_LEN_W-1:0] window_samples_ff;
   logic                 cap_enable_ff;
   logic                 push;
   logic                 pop;
   win_pair_type         push_data;
   win_pair_type         pop_data;
   fifo_stat_type        stat;

   // Write control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_samples_ff <= WINDOW_RESET;
         cap_enable_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_SAMPLES: window_samples_ff <= csr_wdata[CFG_LEN_W-1:0];
            CSR_CAP_ENABLE:     cap_enable_ff     <= csr_wdata[0];
            default: begin
               window_samples_ff <= window_samples_ff;
            end
         endcase
      end
   end

   wmrc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .window_samples (window_samples_ff),
      .stat           (stat),
      .req_if         (req_if),
      .push           (push),
      .push_data      (push_data)
   );

   wmrc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (stat)
   );

   wmrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cap_enable (cap_enable_ff),
      .stat       (stat),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire

>>> design/wmrc_check.sv
`default_nettype none

module wmrc_check
   import wmrc_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic signed [OUT_W-1:0] rsp_relative_change,
   input wire logic                    rsp_saturated
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_relative_change)
                                  && $stable(rsp_saturated))
      else $error("stalled result changed or dropped");

   // No result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Flagged results take only the clip values
   a_sat_values: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_relative_change == OUT_W'(0)) || (rsp_relative_change == OUT_W'(65536))
         || (rsp_relative_change == OUT_W'(8388607)))
      else $error("saturated result has unexpected value");

   // A ratio is never negative, so the change stays at or above minus one
   a_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_relative_change[OUT_W-1] |->
         rsp_relative_change[OUT_W-1:FRAC_BITS] == '1)
      else $error("relative change below minus one");

endmodule

bind window_mean_relative_change_top wmrc_check u_wmrc_check (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_relative_change (rsp_if.relative_change),
   .rsp_saturated       (rsp_if.saturated)
);

`default_nettype wire

>>> bench/window_mean_relative_change_top_test.sv
`default_nettype none

module window_mean_relative_change_top_test;
   import wmrc_pkg::*;

   localparam int      DRAIN_CYCLES = 120;
   localparam longint  Q_UNIT       = 65536;
   localparam longint  OUT_TOP      = 8388607;
   localparam longint  OUT_BOTTOM   = -8388608;
   localparam longint  Q_LIMIT      = OUT_TOP + Q_UNIT + 1;
   localparam longint  SUM_CEILING  = 64'hFFFF_FFFF;
   localparam int      COUNT_LIMIT  = (1 << COUNT_BITS) - 1;
   localparam int      RANDOM_ITEMS = 1950;

   typedef struct packed {
      logic signed [OUT_W-1:0] change;
      logic                    saturated;
   } rel_change_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   wmrc_req_if req_if ();
   wmrc_rsp_if rsp_if ();

   window_mean_relative_change_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Samples waiting for the driver, expected changes waiting for the monitor
   logic [SAMPLE_W-1:0] sample_queue[$];
   rel_change_type      expected_changes[$];

   // Predictor copy of the block state and registers
   logic [15:0] cfg_window;
   logic        cfg_cap;
   logic [63:0] window_total;
   int          window_fill;
   logic [63:0] previous_total;
   logic        priming;

   int  samples_sent;
   int  samples_taken;
   int  changes_checked;
   int  mismatch_count;
   int  settings_count;
   logic req_fire;

   int burst_left;
   int gap_left;
   int ready_run;
   int ready_hold;

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Add one sample to the running window; on a closing window queue the expected change
   task automatic accumulate_sample(input logic [SAMPLE_W-1:0] value);
      longint         change;
      logic [63:0]    quotient;
      logic           sat;
      int             length;
      rel_change_type expected;
      window_total = window_total + (64'(value) & ((64'd1 << SAMPLE_BITS) - 64'd1));
      if (window_total > SUM_CEILING) begin
         window_total = SUM_CEILING;
      end
      if (window_fill < COUNT_LIMIT) begin
         window_fill++;
      end
      length = (cfg_window == 16'd0) ? 1 : int'(cfg_window);
      if (length > COUNT_LIMIT) begin
         length = COUNT_LIMIT;
      end
      if (window_fill >= length) begin
         if (priming) begin
            priming = 1'b0;
         end else begin
            sat = 1'b0;
            if (previous_total == 64'd0) begin
               // zero previous sum: infinite ratio, or zero over zero
               sat = 1'b1;
               if (window_total == 64'd0) begin
                  change = 0;
               end else begin
                  change = cfg_cap ? Q_UNIT : OUT_TOP;
               end
            end else begin
               quotient = ((window_total << FRAC_BITS) + (previous_total >> 1)) / previous_total;
               if (quotient > 64'(Q_LIMIT)) begin
                  quotient = 64'(Q_LIMIT);
               end
               change = longint'(quotient) - Q_UNIT;
               if (cfg_cap) begin
                  if (change > Q_UNIT) begin
                     change = Q_UNIT;
                  end else if (change < -Q_UNIT) begin
                     change = -Q_UNIT;
                  end
               end
               if (change > OUT_TOP) begin
                  change = OUT_TOP;
                  sat = 1'b1;
               end else if (change < OUT_BOTTOM) begin
                  change = OUT_BOTTOM;
                  sat = 1'b1;
               end
            end
            expected.change    = change[OUT_W-1:0];
            expected.saturated = sat;
            expected_changes.push_back(expected);
         end
         previous_total = window_total;
         window_total   = 64'd0;
         window_fill    = 0;
      end
   endtask

   // Wait until every sample is taken and every change checked, then let the back end drain
   task automatic wait_idle();
      while (samples_taken != samples_sent || expected_changes.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // Write both registers on an idle block; return at a rising edge ready for new samples
   task automatic apply_settings(input logic [15:0] window_len, input logic cap_on);
      wait_idle();
      write_csr(CSR_WINDOW_SAMPLES, CSR_W'(window_len));
      write_csr(CSR_CAP_ENABLE, CSR_W'(cap_on));
      csr_we     <= 1'b0;
      cfg_window  = window_len;
      cfg_cap     = cap_on;
      settings_count++;
      @(posedge clock);
   endtask

   task automatic queue_sample(input logic [SAMPLE_W-1:0] value);
      sample_queue.push_back(value);
      samples_sent++;
   endtask

   // Sample driver: bursts of random length separated by random gaps
   always @(negedge clock) begin
      if (!reset && !(req_if.valid && !req_fire)) begin
         if (gap_left != 0) begin
            req_if.valid <= 1'b0;
            gap_left = gap_left - 1;
         end else if (sample_queue.size() != 0) begin
            req_if.valid  <= 1'b1;
            req_if.sample <= sample_queue.pop_front();
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result receiver: runs of ready broken by short and long stalls
   always @(negedge clock) begin
      if (ready_run != 0) begin
         rsp_if.ready <= 1'b1;
         ready_run = ready_run - 1;
      end else if (ready_hold != 0) begin
         rsp_if.ready <= 1'b0;
         ready_hold = ready_hold - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         ready_run = $urandom_range(0, 60);
         case ($urandom_range(0, 3))
            0: ready_hold = 0;
            3: ready_hold = $urandom_range(5, 70);
            default: ready_hold = $urandom_range(1, 4);
         endcase
      end
   end

   // Monitor: check result transfers first, then predict from sample transfers
   always @(posedge clock) begin
      rel_change_type expected;
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_changes.size() == 0) begin
               $display("%0t: unexpected result relative_change %0d saturated %0b", $time,
                        $signed(rsp_if.relative_change), rsp_if.saturated);
               mismatch_count++;
            end else begin
               expected = expected_changes.pop_front();
               changes_checked++;
               if (rsp_if.relative_change !== expected.change) begin
                  $display("%0t: relative_change expected %0d, actual %0d", $time,
                           $signed(expected.change), $signed(rsp_if.relative_change));
                  mismatch_count++;
               end
               if (rsp_if.saturated !== expected.saturated) begin
                  $display("%0t: saturated expected %0b, actual %0b", $time,
                           expected.saturated, rsp_if.saturated);
                  mismatch_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            samples_taken++;
            accumulate_sample(req_if.sample);
         end
      end
   end

   // Stimulus
   initial begin
      int          mode;
      int          base;
      int          count;
      int          pick;
      logic [15:0] window_len;
      logic [15:0] value;

      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.sample  = '0;
      rsp_if.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_WINDOW_SAMPLES;
      csr_wdata      = '0;
      req_fire       = 1'b0;
      cfg_window     = WINDOW_RESET;
      cfg_cap        = 1'b0;
      window_total   = 64'd0;
      window_fill    = 0;
      previous_total = 64'd0;
      priming        = 1'b1;
      samples_sent    = 0;
      samples_taken   = 0;
      changes_checked = 0;
      mismatch_count  = 0;
      settings_count  = 0;
      burst_left = 0;
      gap_left   = 0;
      ready_run  = 0;
      ready_hold = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // One-sample windows: priming, zero over zero, zero previous sum, range clipping
      apply_settings(16'd1, 1'b0);
      queue_sample(16'd0);
      queue_sample(16'd0);
      queue_sample(16'hFFFF);
      queue_sample(16'd1);
      queue_sample(16'hFFFF);
      queue_sample(16'd2);
      queue_sample(16'd3);
      queue_sample(16'hFFFE);

      // Zero length acts as one; cap clips from above and on a zero previous sum
      apply_settings(16'd0, 1'b1);
      queue_sample(16'd0);
      queue_sample(16'd100);
      queue_sample(16'hFFFF);
      queue_sample(16'd0);
      queue_sample(16'd0);

      // Shorten a partly filled window: it closes on the next sample
      apply_settings(16'd4, 1'b0);
      queue_sample(16'd40000);
      queue_sample(16'd40001);
      queue_sample(16'd39999);
      apply_settings(16'd2, 1'b1);
      queue_sample(16'd7);
      queue_sample(16'd1);
      queue_sample(16'd1);

      // Longest window, left partly filled and then cut short
      apply_settings(16'hFFFF, 1'b0);
      queue_sample(16'hAAAA);
      queue_sample(16'h5555);
      queue_sample(16'hFFFF);
      queue_sample(16'd0);
      apply_settings(16'd3, 1'b0);
      queue_sample(16'd9);
      queue_sample(16'd12345);

      // Random phases: mostly short windows, random content shaped per phase
      while (samples_sent < RANDOM_ITEMS + 25) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            window_len = 16'd0;
         end else if (pick < 45) begin
            window_len = 16'($urandom_range(1, 4));
         end else if (pick < 80) begin
            window_len = 16'($urandom_range(5, 16));
         end else if (pick < 95) begin
            window_len = 16'($urandom_range(17, 300));
         end else begin
            window_len = 16'hFFFF;
         end
         apply_settings(window_len, 1'($urandom_range(0, 1)));
         mode  = $urandom_range(0, 4);
         base  = $urandom_range(8, 65527);
         count = $urandom_range(8, 100);
         repeat (count) begin
            case (mode)
               0: value = 16'($urandom_range(0, 65535));
               1: value = 16'(base - 8 + $urandom_range(0, 16));
               2: value = 16'($urandom_range(0, 3));
               3: begin
                  case ($urandom_range(0, 3))
                     0: value = 16'd0;
                     1: value = 16'hFFFF;
                     2: value = 16'd1;
                     default: value = 16'hFFFE;
                  endcase
               end
               default: value = ($urandom_range(0, 9) < 7) ? 16'd0 : 16'($urandom);
            endcase
            queue_sample(value);
         end
      end

      wait_idle();
      $display("Checked %0d relative-change results from %0d samples under %0d register settings.",
               changes_checked, samples_taken, settings_count);
      $display("Window lengths ran from zero to the maximum, with the cap both off and on.");
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
